// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define DSFQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define DSFQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/dsfq_pkg.sv
package dsfq_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned SLOT_W = 5;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_ENABLE  = 2'd2,
    FUNC_DISABLE = 2'd3
  } func_e;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic              src;
    logic              none;
  } cmd_t;

endpackage

// File: rtl/dsfq_ram.sv
module dsfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/dsfq_cmd_fifo.sv
module dsfq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dsfq_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dsfq_pkg::cmd_t data_o
);
  import dsfq_pkg::*;

  cmd_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] occ_q;

  assign full_o  = (occ_q == 2'd2);
  assign valid_o = (occ_q != 2'd0);
  assign data_o  = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      occ_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      occ_q <= occ_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: rtl/dsfq_front.sv
module dsfq_front #(
  parameter int unsigned QUEUE_SLOTS = 4,
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  output logic                                  full_o,
  input  logic [1:0]                            func_i,
  input  logic                                  source_i,
  input  logic [dsfq_pkg::BYTE_W-1:0]           byte_i,
  input  logic                                  last_i,
  output logic                                  wr_en_o,
  output logic [$clog2(QUEUE_SLOTS+2)+((FRAME_BYTES>1)?$clog2(FRAME_BYTES):1)-1:0] wr_addr_o,
  output logic [dsfq_pkg::BYTE_W-1:0]           wr_data_o,
  output logic                                  cmd_push_o,
  output dsfq_pkg::cmd_t                        cmd_o,
  input  logic                                  cmd_full_i,
  input  logic                                  release_i,
  input  logic [dsfq_pkg::SLOT_W-1:0]           release_slot_i,
  output logic [$clog2(QUEUE_SLOTS+1)-1:0]      count_o
);
  import dsfq_pkg::*;

  localparam int unsigned NSLOT = QUEUE_SLOTS + 2;
  localparam int unsigned SW    = $clog2(NSLOT);
  localparam int unsigned IDXW  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned LENW  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned CW    = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned PW    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

  logic [SW-1:0]    ord_q [QUEUE_SLOTS];
  logic [SW-1:0]    ord_d [QUEUE_SLOTS];
  logic [LENW-1:0]  len_q [QUEUE_SLOTS];
  logic [LENW-1:0]  len_d [QUEUE_SLOTS];
  logic             src_q [QUEUE_SLOTS];
  logic             src_d [QUEUE_SLOTS];
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             act_q, act_d;
  logic [NSLOT-1:0] used_q, used_d, pend_q, pend_d;
  logic [SW-1:0]    stg_q, stg_d;
  logic [LENW-1:0]  scnt_q, scnt_d;
  logic             sovf_q, sovf_d;

  logic [NSLOT-1:0] free;
  logic             free_any;
  logic [SW-1:0]    free_idx;
  logic             acc;
  logic             ovf_n;
  logic             hit;
  logic [PW-1:0]    pidx;
  logic [SW-1:0]    pslot;

  always_comb begin
    free     = ~used_q & ~pend_q;
    free[stg_q] = 1'b0;
    free_any = |free;
    free_idx = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (free[i]) free_idx = SW'(i);
    end
  end

  assign full_o    = cmd_full_i || !free_any;
  assign acc       = push_i && !full_o;
  assign count_o   = cnt_q;
  assign wr_addr_o = {stg_q, scnt_q[IDXW-1:0]};
  assign wr_data_o = byte_i;

  always_comb begin
    hit  = 1'b0;
    pidx = '0;
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      if (!hit && (CW'(i) < cnt_q) && (src_q[i] == act_q)) begin
        hit  = 1'b1;
        pidx = PW'(i);
      end
    end
    pslot = ord_q[pidx];
  end

  always_comb begin
    ord_d      = ord_q;
    len_d      = len_q;
    src_d      = src_q;
    cnt_d      = cnt_q;
    act_d      = act_q;
    used_d     = used_q;
    pend_d     = pend_q;
    stg_d      = stg_q;
    scnt_d     = scnt_q;
    sovf_d     = sovf_q;
    ovf_n      = 1'b0;
    wr_en_o    = 1'b0;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    if (release_i) begin
      pend_d[release_slot_i[SW-1:0]] = 1'b0;
    end
    if (acc) begin
      unique case (func_e'(func_i))
        FUNC_PUSH: begin
          if (scnt_q < LENW'(FRAME_BYTES)) begin
            wr_en_o = 1'b1;
            scnt_d  = scnt_q + 1'b1;
          end else begin
            sovf_d = 1'b1;
          end
          if (last_i) begin
            ovf_n  = sovf_q || (scnt_q == LENW'(FRAME_BYTES));
            scnt_d = '0;
            sovf_d = 1'b0;
            if (!ovf_n) begin
              if (cnt_q == CW'(QUEUE_SLOTS)) begin
                for (int i = 0; i < QUEUE_SLOTS - 1; i++) begin
                  ord_d[i] = ord_q[i+1];
                  len_d[i] = len_q[i+1];
                  src_d[i] = src_q[i+1];
                end
                ord_d[QUEUE_SLOTS-1] = stg_q;
                len_d[QUEUE_SLOTS-1] = scnt_q + 1'b1;
                src_d[QUEUE_SLOTS-1] = source_i;
                used_d[ord_q[0]]     = 1'b0;
                used_d[stg_q]        = 1'b1;
                stg_d                = ord_q[0];
              end else begin
                for (int i = 0; i < QUEUE_SLOTS; i++) begin
                  if (CW'(i) == cnt_q) begin
                    ord_d[i] = stg_q;
                    len_d[i] = scnt_q + 1'b1;
                    src_d[i] = source_i;
                  end
                end
                used_d[stg_q] = 1'b1;
                stg_d         = free_idx;
                cnt_d         = cnt_q + 1'b1;
              end
            end
          end
        end
        FUNC_POP: begin
          cmd_push_o = 1'b1;
          if (cnt_q == '0) begin
            cmd_o.none = 1'b1;
          end else begin
            cmd_o.slot = SLOT_W'(pslot);
            cmd_o.len  = LEN_W'(len_q[pidx]);
            cmd_o.src  = src_q[pidx];
            act_d      = src_q[pidx];
            for (int i = 0; i < QUEUE_SLOTS - 1; i++) begin
              if (PW'(i) >= pidx) begin
                ord_d[i] = ord_q[i+1];
                len_d[i] = len_q[i+1];
                src_d[i] = src_q[i+1];
              end
            end
            used_d[pslot] = 1'b0;
            pend_d[pslot] = 1'b1;
            cnt_d         = cnt_q - 1'b1;
          end
        end
        FUNC_ENABLE: begin
          cnt_d  = '0;
          used_d = '0;
          act_d  = 1'b0;
        end
        FUNC_DISABLE: begin
          cnt_d  = '0;
          used_d = '0;
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q <= ord_d;
    len_q <= len_d;
    src_q <= src_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      act_q  <= 1'b0;
      used_q <= '0;
      pend_q <= '0;
      stg_q  <= '0;
      scnt_q <= '0;
      sovf_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      act_q  <= act_d;
      used_q <= used_d;
      pend_q <= pend_d;
      stg_q  <= stg_d;
      scnt_q <= scnt_d;
      sovf_q <= sovf_d;
    end
  end

endmodule

// File: rtl/dsfq_back.sv
module dsfq_back #(
  parameter int unsigned QUEUE_SLOTS = 4,
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  dsfq_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  output logic                        rd_en_o,
  output logic [$clog2(QUEUE_SLOTS+2)+((FRAME_BYTES>1)?$clog2(FRAME_BYTES):1)-1:0] rd_addr_o,
  input  logic [dsfq_pkg::BYTE_W-1:0] rd_data_i,
  output logic                        release_o,
  output logic [dsfq_pkg::SLOT_W-1:0] release_slot_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [dsfq_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        out_last_o,
  output logic                        out_source_o,
  output logic [dsfq_pkg::LEN_W-1:0]  frame_length_o,
  output logic                        queue_empty_o
);
  import dsfq_pkg::*;

  localparam int unsigned SW   = $clog2(QUEUE_SLOTS + 2);
  localparam int unsigned IDXW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned LENW = $clog2(FRAME_BYTES + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              src;
    logic [LEN_W-1:0]  len;
    logic              none;
  } res_t;

  logic            busy_q, busy_d;
  cmd_t            cur_q, cur_d;
  logic [LENW-1:0] idx_q, idx_d;
  logic            infl_q, infl_d;
  res_t            meta_q, meta_d;
  res_t            ob_q [4];
  logic [1:0]      wp_q, rp_q;
  logic [2:0]      occ_q;
  logic            room, issue, last_n, deq;
  res_t            head;
  res_t            ob_wr;

  assign deq    = pop_i && !empty_o;
  assign room   = (occ_q + {2'b0, infl_q}) < 3'd4;
  assign issue  = busy_q && room;
  assign last_n = cur_q.none || ((LEN_W'(idx_q) + 1'b1) == cur_q.len);

  assign rd_en_o        = issue && !cur_q.none;
  assign rd_addr_o      = {cur_q.slot[SW-1:0], idx_q[IDXW-1:0]};
  assign release_o      = issue && last_n && !cur_q.none;
  assign release_slot_o = cur_q.slot;

  always_comb begin
    busy_d    = busy_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    infl_d    = issue;
    meta_d    = meta_q;
    cmd_pop_o = 1'b0;
    if (!busy_q && cmd_valid_i) begin
      cmd_pop_o = 1'b1;
      busy_d    = 1'b1;
      cur_d     = cmd_i;
      idx_d     = '0;
    end
    if (issue) begin
      meta_d.data = '0;
      meta_d.last = last_n;
      meta_d.src  = cur_q.src;
      meta_d.len  = cur_q.len;
      meta_d.none = cur_q.none;
      idx_d       = idx_q + 1'b1;
      if (last_n) busy_d = 1'b0;
    end
  end

  always_comb begin
    ob_wr      = meta_q;
    ob_wr.data = meta_q.none ? '0 : rd_data_i;
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    meta_q <= meta_d;
    if (infl_q) begin
      ob_q[wp_q] <= ob_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      infl_q <= 1'b0;
      wp_q   <= '0;
      rp_q   <= '0;
      occ_q  <= '0;
    end else begin
      busy_q <= busy_d;
      infl_q <= infl_d;
      if (infl_q) wp_q <= wp_q + 1'b1;
      if (deq)    rp_q <= rp_q + 1'b1;
      occ_q  <= occ_q + {2'b0, infl_q} - {2'b0, deq};
    end
  end

  assign head           = ob_q[rp_q];
  assign empty_o        = (occ_q == '0);
  assign out_byte_o     = head.data;
  assign out_last_o     = head.last;
  assign out_source_o   = head.src;
  assign frame_length_o = head.len;
  assign queue_empty_o  = head.none;

endmodule

// File: rtl/dual_source_frame_queue_unit.sv
// channel   direction  handshake     fields
// input     in         push / full   func_i in_source_i in_byte_i in_last_i
// result    out        pop / empty   out_byte_o out_last_o out_source_o
//                                    frame_length_o queue_empty_o
// The front takes a push, enable, disable or pop transfer whenever full is low.
// The back streams one result per cycle from the frame store read port, loads each
// frame's command from the command queue before it streams that frame, and halts
// while its four-entry buffer is full.
// Reset clears all control state; the frame store needs no clearing.
// full rises while the command queue holds two pops or no slot is free to stage into.
module dual_source_frame_queue_unit #(
  parameter int unsigned FRAME_BYTES = 64,
  parameter int unsigned QUEUE_SLOTS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  func_i,
  input  logic                        in_source_i,
  input  logic [dsfq_pkg::BYTE_W-1:0] in_byte_i,
  input  logic                        in_last_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [dsfq_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        out_last_o,
  output logic                        out_source_o,
  output logic [dsfq_pkg::LEN_W-1:0]  frame_length_o,
  output logic                        queue_empty_o
);
  import dsfq_pkg::*;

  localparam int unsigned NSLOT = QUEUE_SLOTS + 2;
  localparam int unsigned IDXW  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned AW    = $clog2(NSLOT) + IDXW;
  localparam int unsigned DEPTH = NSLOT << IDXW;
  localparam int unsigned CW    = $clog2(QUEUE_SLOTS + 1);

  logic              wr_en, rd_en, cmd_push, cmd_full, cmd_valid, cmd_pop, rel;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;
  logic [SLOT_W-1:0] rel_slot;
  logic [CW-1:0]     count;
  cmd_t              cmd_in, cmd_out;

  dsfq_front #(.QUEUE_SLOTS(QUEUE_SLOTS), .FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .func_i, .source_i(in_source_i), .byte_i(in_byte_i), .last_i(in_last_i),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .cmd_push_o(cmd_push), .cmd_o(cmd_in), .cmd_full_i(cmd_full),
    .release_i(rel), .release_slot_i(rel_slot), .count_o(count)
  );

  dsfq_cmd_fifo u_cmdq (
    .clk_i, .rst_ni,
    .push_i(cmd_push), .data_i(cmd_in), .full_o(cmd_full),
    .pop_i(cmd_pop), .valid_o(cmd_valid), .data_o(cmd_out)
  );

  dsfq_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_store (
    .clk_i,
    .we_i(wr_en), .waddr_i(wr_addr), .wdata_i(wr_data),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(rd_data)
  );

  dsfq_back #(.QUEUE_SLOTS(QUEUE_SLOTS), .FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd_out), .cmd_pop_o(cmd_pop),
    .rd_en_o(rd_en), .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .release_o(rel), .release_slot_o(rel_slot),
    .empty_o(empty), .pop_i(pop),
    .out_byte_o, .out_last_o, .out_source_o, .frame_length_o, .queue_empty_o
  );

`include "assert_macros.svh"

  `DSFQ_ASSERT(a_count_bound, count <= CW'(QUEUE_SLOTS), "stored frame count above limit")
  `DSFQ_ASSERT(a_empty_res, (!empty && queue_empty_o) |-> (out_last_o && frame_length_o == '0), "bad empty-queue result")
  `DSFQ_NEVER(a_zero_len, !empty && !queue_empty_o && frame_length_o == '0, "frame result with zero length")

endmodule

// File: tb/frame_queue_checker.sv
`timescale 1ns / 1ps

module frame_queue_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic       full,
  input  logic [1:0] func_i,
  input  logic       in_source_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte_o,
  input  logic       out_last_o,
  input  logic       out_source_o,
  input  logic [6:0] frame_length_o,
  input  logic       queue_empty_o,
  output int         fail_count,
  output int         pending_count
);
  import dsfq_pkg::*;

  localparam int FRAME_MAX = 64;
  localparam int SLOT_MAX  = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       src;
    logic [6:0] len;
    logic       none;
  } beat_t;

  logic [7:0] store_data [SLOT_MAX][FRAME_MAX];
  logic [6:0] store_len [SLOT_MAX];
  logic       store_src [SLOT_MAX];
  int         store_used;
  logic       cur_src;
  logic [7:0] stage_data [FRAME_MAX];
  int         stage_used;
  logic       stage_over;
  beat_t      beats_due [$];

  assign pending_count = beats_due.size();

  task automatic remove_frame(input int idx);
    for (int j = idx; j + 1 < store_used; j++) begin
      store_data[j] = store_data[j + 1];
      store_len[j]  = store_len[j + 1];
      store_src[j]  = store_src[j + 1];
    end
    store_used--;
  endtask

  task automatic model_transfer(input func_e f, input logic s, input logic [7:0] b,
                                input logic l);
    int    pick;
    beat_t e;
    case (f)
      FUNC_PUSH: begin
        if (stage_used < FRAME_MAX) begin
          stage_data[stage_used] = b;
          stage_used++;
        end else begin
          stage_over = 1'b1;
        end
        if (l) begin
          if (stage_used != 0 && !stage_over) begin
            if (store_used >= SLOT_MAX) remove_frame(0);
            for (int i = 0; i < stage_used; i++) store_data[store_used][i] = stage_data[i];
            store_len[store_used] = 7'(stage_used);
            store_src[store_used] = s;
            store_used++;
          end
          stage_used = 0;
          stage_over = 1'b0;
        end
      end
      FUNC_ENABLE: begin
        store_used = 0;
        cur_src = 1'b0;
      end
      FUNC_DISABLE: store_used = 0;
      default: begin
        if (store_used == 0) begin
          e = '{data: 8'd0, last: 1'b1, src: 1'b0, len: 7'd0, none: 1'b1};
          beats_due.push_back(e);
        end else begin
          pick = 0;
          for (int i = 0; i < store_used; i++)
            if (store_src[i] == cur_src) begin
              pick = i;
              break;
            end
          cur_src = store_src[pick];
          for (int i = 0; i < store_len[pick]; i++) begin
            e = '{data: store_data[pick][i], last: (i + 1 == store_len[pick]),
                  src: cur_src, len: store_len[pick], none: 1'b0};
            beats_due.push_back(e);
          end
          remove_frame(pick);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t e;
    int    errs;
    errs = 0;
    if (!rst_ni) begin
      store_used <= 0;
      cur_src    <= 1'b0;
      stage_used <= 0;
      stage_over <= 1'b0;
      fail_count <= 0;
      beats_due.delete();
    end else begin
      if (push && !full) model_transfer(func_e'(func_i), in_source_i, in_byte_i, in_last_i);
      if (pop && !empty) begin
        if (beats_due.size() == 0) begin
          $error("unexpected result transfer");
          errs++;
        end else begin
          e = beats_due.pop_front();
          if (out_byte_o !== e.data) begin
            $error("out_byte exp %0d got %0d", e.data, out_byte_o);
            errs++;
          end
          if (out_last_o !== e.last) begin
            $error("out_last exp %0d got %0d", e.last, out_last_o);
            errs++;
          end
          if (out_source_o !== e.src) begin
            $error("out_source exp %0d got %0d", e.src, out_source_o);
            errs++;
          end
          if (frame_length_o !== e.len) begin
            $error("frame_length exp %0d got %0d", e.len, frame_length_o);
            errs++;
          end
          if (queue_empty_o !== e.none) begin
            $error("queue_empty exp %0d got %0d", e.none, queue_empty_o);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dsfq_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [1:0] func_i;
  logic       in_source_i;
  logic [7:0] in_byte_i;
  logic       in_last_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       out_source_o;
  logic [6:0] frame_length_o;
  logic       queue_empty_o;
  int         fail_count;
  int         pending_count;
  int         stall_phase;
  int         sent;

  dual_source_frame_queue_unit dut (.*);
  frame_queue_checker chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("dual_source_frame_queue_unit: mismatch");
    $finish;
  end

  // receiver: fixed stall pattern with occasional random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop         <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 97;
      pop <= (stall_phase < 40) ? 1'b1 : ((stall_phase % 5) != 0 && $urandom_range(3) != 0);
    end
  end

  task automatic send(input func_e f, input logic s, input logic [7:0] b, input logic l);
    push        <= 1'b1;
    func_i      <= f;
    in_source_i <= s;
    in_byte_i   <= b;
    in_last_i   <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
  endtask

  task automatic rest();
    push <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic s, input int n, input bit ramp);
    for (int i = 0; i < n; i++)
      send(FUNC_PUSH, s, ramp ? 8'(i) : 8'($urandom), i == n - 1);
  endtask

  initial begin
    int  n;
    int  burst;
    int  roll;
    sent        = 0;
    push        = 1'b0;
    func_i      = FUNC_PUSH;
    in_source_i = 1'b0;
    in_byte_i   = 8'd0;
    in_last_i   = 1'b0;
    rst_ni      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(FUNC_POP, 1'b0, 8'hff, 1'b1);
    send(FUNC_PUSH, 1'b1, 8'hff, 1'b1);
    send(FUNC_PUSH, 1'b0, 8'h00, 1'b0);
    send(FUNC_PUSH, 1'b0, 8'hff, 1'b1);
    send(FUNC_POP, 1'b0, 8'h00, 1'b0);
    send(FUNC_POP, 1'b1, 8'h00, 1'b0);
    send(FUNC_ENABLE, 1'b1, 8'hff, 1'b1);
    send(FUNC_DISABLE, 1'b0, 8'h00, 1'b0);
    send_frame(1'b1, 64, 1'b1);
    send_frame(1'b0, 66, 1'b1);
    send(FUNC_POP, 1'b0, 8'h00, 1'b0);
    for (int k = 0; k < 5; k++) send_frame(k[0], 2, 1'b0);
    send(FUNC_POP, 1'b0, 8'h00, 1'b0);
    send(FUNC_POP, 1'b0, 8'h00, 1'b0);
    rest();
    wait (pending_count == 0);
    @(posedge clk_i);
    send(FUNC_ENABLE, 1'b0, 8'h00, 1'b0);

    while (sent < 180) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < 180; b++) begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          n = ($urandom_range(15) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
          send_frame(1'($urandom), n, 1'b0);
        end else if (roll < 88) begin
          send(FUNC_POP, 1'($urandom), 8'($urandom), 1'($urandom));
        end else if (roll < 94) begin
          send(FUNC_PUSH, 1'($urandom), 8'($urandom), 1'($urandom));
        end else begin
          send(roll < 97 ? FUNC_ENABLE : FUNC_DISABLE, 1'($urandom), 8'($urandom),
               1'($urandom));
        end
      end
      if (sent % 60 < 12) begin
        push <= 1'b0;
        wait (pending_count == 0);
        @(posedge clk_i);
      end else begin
        rest();
      end
    end
    push <= 1'b0;
    wait (pending_count == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("dual_source_frame_queue_unit: match");
    end else begin
      $display("dual_source_frame_queue_unit: mismatch");
    end
    $finish;
  end
endmodule
